>>> rtl/core/rou_pkg.sv
package rou_pkg;

	localparam int ORD_W = 16;
	localparam int MOD_W = 62;

	typedef struct packed {
		logic [MOD_W-1:0] modulus;
		logic [ORD_W-1:0] order;
	} req_t;

	typedef struct packed {
		logic [MOD_W-1:0] root;
		logic [1:0]       status;
	} rsp_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NODIV,
		STAT_LIMIT,
		STAT_OVERFLOW
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DWAIT,
		S_FCHK,
		S_FSTRIP,
		S_FWAIT,
		S_FTAIL,
		S_GCHK,
		S_PBIT,
		S_PMR,
		S_PMB,
		S_PEND,
		S_QCHK,
		S_QWAIT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_FERMAT,
		PH_CAND,
		PH_TEST
	} phase_t;

endpackage

>>> rtl/core/rou_mulmod.sv
// Bit-serial modular multiplier: one double step and one conditional add step per bit.
module rou_mulmod #(
	parameter int W = 62
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] p,
	output logic         done,
	output logic [W-1:0] res
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q, b_q, p_q, r_q;
	logic [CW-1:0] cnt_q;
	logic          add_q, busy_q, done_q;
	logic [W:0]    sum, diff;
	logic [W-1:0]  r_next;

	always_comb begin
		if (add_q) begin
			sum = {1'b0, r_q} + {1'b0, a_q};
		end else begin
			sum = {r_q, 1'b0};
		end
		diff = sum - {1'b0, p_q};
		if (sum >= {1'b0, p_q}) begin
			r_next = diff[W-1:0];
		end else begin
			r_next = sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			add_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				add_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				add_q <= !add_q;
				if (add_q) begin
					if (cnt_q == CW'(W - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= p;
			r_q <= '0;
		end else if (busy_q) begin
			if (add_q) begin
				if (b_q[W-1]) begin
					r_q <= r_next;
				end
				b_q <= {b_q[W-2:0], 1'b0};
			end else begin
				r_q <= r_next;
			end
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

>>> rtl/core/rou_div.sv
// Restoring divider, one quotient bit per cycle, divisor of order width.
module rou_div import rou_pkg::*; #(
	parameter int W = 62
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     num,
	input  logic [ORD_W-1:0] den,
	output logic             done,
	output logic [W-1:0]     quot,
	output logic [ORD_W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]     q_q;
	logic [ORD_W-1:0] r_q, d_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [ORD_W:0]   shifted, diff;

	always_comb begin
		shifted = {r_q, q_q[W-1]};
		diff    = shifted - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (shifted >= {1'b0, d_q}) begin
				r_q <= diff[ORD_W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted[ORD_W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

>>> rtl/core/mth_root_of_unity_mod_prime.sv
// Finds a primitive order-th root of unity modulo a prime. For each request the block checks
// that the order divides modulus minus one (status 1 otherwise, and also for a modulus below 3
// or an order of 0), factors the order by trial division, and then tries bases 2, 3, ... up to
// MAX_BASE and below the modulus: a base passes the Fermat test g^(p-1) = 1, its candidate
// g^((p-1)/m) must differ from 1, and the candidate raised to m/q must differ from 1 for every
// prime factor q. The first surviving candidate is returned with status 0; when no base
// survives the status is 2, and when the order has more than MAX_PRIME_FACTORS distinct prime
// factors it is 3. Root is 0 unless status is 0. One request is worked on at a time and the
// input is stalled until its response is registered. All modular products and divisions run
// through one shared bit-serial modular multiplier and one shared restoring divider. A modular
// exponentiation costs up to 2*MODULUS_BITS products; the total running time is set by the
// number of bases tried plus up to about 255 divisions for the factoring of the order.
module mth_root_of_unity_mod_prime import rou_pkg::*; #(
	parameter int MODULUS_BITS      = 62,
	parameter int MAX_PRIME_FACTORS = 8,
	parameter int MAX_BASE          = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  req_t src_data,
	output logic dst_valid,
	input  logic dst_stall,
	output rsp_t dst_data
);

	localparam int W   = MODULUS_BITS;
	localparam int DW  = (W > ORD_W) ? W : ORD_W;
	localparam int NFW = $clog2(MAX_PRIME_FACTORS + 1);
	localparam int FIW = (MAX_PRIME_FACTORS > 1) ? $clog2(MAX_PRIME_FACTORS) : 1;
	localparam int GW  = $clog2(MAX_BASE + 2);
	localparam int XW  = (GW > W) ? GW : W;
	localparam logic [GW-1:0]  BaseLim = GW'(MAX_BASE);
	localparam logic [NFW-1:0] FacLim  = NFW'(MAX_PRIME_FACTORS);

	state_t state_q, state_d;
	phase_t phase_q;

	logic [W-1:0]     p_q, e_q, r_q, b_q, x_q, cand_q, root_q;
	logic [ORD_W-1:0] m_q, rest_q;
	logic [ORD_W-1:0] fac_q [MAX_PRIME_FACTORS];
	logic [8:0]       d_q;
	logic [NFW-1:0]   nf_q, i_q;
	logic [GW-1:0]    g_q;
	logic             strip_q;
	stat_t            stat_q;
	logic             dst_valid_q;
	rsp_t             dst_data_q;

	logic [W-1:0]     phi;
	logic [63:0]      mod_ext;
	logic [17:0]      dd;
	logic             base_ok, full;

	logic             mul_start, mul_done;
	logic [W-1:0]     mul_a, mul_res;
	logic             div_start, div_done;
	logic [DW-1:0]    div_num, div_quot;
	logic [ORD_W-1:0] div_den, div_rem;

	assign mod_ext = {2'b00, src_data.modulus};
	assign phi     = p_q - 1'b1;
	assign dd      = d_q * d_q;
	assign base_ok = (g_q <= BaseLim) && (XW'(g_q) < XW'(p_q));
	assign full    = (nf_q >= FacLim);
	assign mul_a   = (state_q == S_PBIT && x_q[0]) ? r_q : b_q;

	always_comb begin
		case (state_q)
			S_CHECK: begin
				div_num = DW'(phi);
				div_den = m_q;
			end
			S_QCHK: begin
				div_num = DW'(m_q);
				div_den = fac_q[i_q[FIW-1:0]];
			end
			default: begin
				div_num = DW'(rest_q);
				div_den = ORD_W'(d_q);
			end
		endcase
	end

	rou_mulmod #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (b_q),
		.p      (p_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	rou_div #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// Sequencer: next state and start pulses for the two shared units.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (src_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (p_q < W'(3) || m_q == '0) begin
					state_d = S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = S_DWAIT;
				end
			end
			S_DWAIT: begin
				if (div_done) begin
					state_d = (div_rem != '0) ? S_DONE : S_FCHK;
				end
			end
			S_FCHK: begin
				if (dd <= {2'b00, rest_q}) begin
					div_start = 1'b1;
					state_d   = S_FWAIT;
				end else begin
					state_d = S_FTAIL;
				end
			end
			S_FSTRIP: begin
				div_start = 1'b1;
				state_d   = S_FWAIT;
			end
			S_FWAIT: begin
				if (div_done) begin
					if (div_rem != '0) begin
						state_d = S_FCHK;
					end else if (!strip_q && full) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FSTRIP;
					end
				end
			end
			S_FTAIL: begin
				state_d = (rest_q > ORD_W'(1) && full) ? S_DONE : S_GCHK;
			end
			S_GCHK: begin
				state_d = base_ok ? S_PBIT : S_DONE;
			end
			S_PBIT: begin
				if (x_q == '0) begin
					state_d = S_PEND;
				end else begin
					mul_start = 1'b1;
					state_d   = x_q[0] ? S_PMR : S_PMB;
				end
			end
			S_PMR: begin
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = S_PMB;
				end
			end
			S_PMB: begin
				if (mul_done) begin
					state_d = S_PBIT;
				end
			end
			S_PEND: begin
				case (phase_q)
					PH_FERMAT: state_d = (r_q == W'(1)) ? S_PBIT : S_GCHK;
					PH_CAND:   state_d = (r_q == W'(1)) ? S_GCHK : S_QCHK;
					default:   state_d = (r_q == W'(1)) ? S_GCHK : S_QCHK;
				endcase
			end
			S_QCHK: begin
				if (i_q == nf_q) begin
					state_d = S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = S_QWAIT;
				end
			end
			S_QWAIT: begin
				if (div_done) begin
					state_d = S_PBIT;
				end
			end
			S_DONE: begin
				if (!dst_valid_q || !dst_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dst_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dst_valid_q && !dst_stall) begin
				dst_valid_q <= 1'b0;
			end
			if (state_q == S_DONE && (!dst_valid_q || !dst_stall)) begin
				dst_valid_q <= 1'b1;
			end
		end
	end

	// Datapath registers, updated by the state the sequencer is in.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (src_valid) begin
					p_q    <= mod_ext[W-1:0];
					m_q    <= src_data.order;
					stat_q <= STAT_NODIV;
					root_q <= '0;
				end
			end
			S_DWAIT: begin
				if (div_done) begin
					e_q     <= div_quot[W-1:0];
					rest_q  <= m_q;
					d_q     <= 9'd2;
					nf_q    <= '0;
					strip_q <= 1'b0;
				end
			end
			S_FWAIT: begin
				if (div_done) begin
					if (div_rem != '0) begin
						strip_q <= 1'b0;
						d_q     <= d_q + 1'b1;
					end else if (!strip_q && full) begin
						stat_q <= STAT_OVERFLOW;
					end else begin
						if (!strip_q) begin
							fac_q[nf_q[FIW-1:0]] <= ORD_W'(d_q);
							nf_q                 <= nf_q + 1'b1;
						end
						strip_q <= 1'b1;
						rest_q  <= div_quot[ORD_W-1:0];
					end
				end
			end
			S_FTAIL: begin
				g_q <= GW'(2);
				if (rest_q > ORD_W'(1)) begin
					if (full) begin
						stat_q <= STAT_OVERFLOW;
					end else begin
						fac_q[nf_q[FIW-1:0]] <= rest_q;
						nf_q                 <= nf_q + 1'b1;
					end
				end
			end
			S_GCHK: begin
				if (base_ok) begin
					r_q     <= W'(1);
					b_q     <= W'(g_q);
					x_q     <= phi;
					phase_q <= PH_FERMAT;
				end else begin
					stat_q <= STAT_LIMIT;
				end
			end
			S_PMR: begin
				if (mul_done) begin
					r_q <= mul_res;
				end
			end
			S_PMB: begin
				if (mul_done) begin
					b_q <= mul_res;
					x_q <= x_q >> 1;
				end
			end
			S_PEND: begin
				case (phase_q)
					PH_FERMAT: begin
						if (r_q == W'(1)) begin
							b_q     <= W'(g_q);
							x_q     <= e_q;
							phase_q <= PH_CAND;
						end else begin
							g_q <= g_q + 1'b1;
						end
					end
					PH_CAND: begin
						cand_q <= r_q;
						i_q    <= '0;
						if (r_q == W'(1)) begin
							g_q <= g_q + 1'b1;
						end
					end
					default: begin
						if (r_q == W'(1)) begin
							g_q <= g_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				endcase
			end
			S_QCHK: begin
				if (i_q == nf_q) begin
					stat_q <= STAT_OK;
					root_q <= cand_q;
				end
			end
			S_QWAIT: begin
				if (div_done) begin
					r_q     <= W'(1);
					b_q     <= cand_q;
					x_q     <= W'(div_quot[ORD_W-1:0]);
					phase_q <= PH_TEST;
				end
			end
			S_DONE: begin
				if (!dst_valid_q || !dst_stall) begin
					dst_data_q.root   <= MOD_W'(root_q);
					dst_data_q.status <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign src_stall = (state_q != S_IDLE);
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	// A request is taken only from idle, so the input stalls right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("input not stalled after request accept");

	// Root is zero on every failure status.
	a_root_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.status != STAT_OK |-> dst_data.root == '0)
		else $error("nonzero root with failure status");

	// A successful root is never the trivial value one.
	a_root_not_one: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.status == STAT_OK |-> dst_data.root != MOD_W'(1))
		else $error("trivial root reported as ok");

endmodule
